// File: design/tbe_pkg.sv
package tbe_pkg;

  localparam int MAX_ROWS_DEF      = 256;
  localparam int MAX_COLS_DEF      = 256;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int ELEV_W     = 24;
  localparam int LAT_W      = 30;
  localparam int LON_W      = 31;
  localparam int RATE_W     = 33;
  localparam int RATE_FRAC  = 16;
  localparam int PROD_FRAC  = 38;
  localparam int DIM_W      = 9;
  localparam int IDX_W      = 8;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 33;

  localparam logic [RATE_W-1:0] RATE_RST = 33'd65536;
  localparam logic [DIM_W-1:0]  DIM_RST  = 9'd256;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORG_LAT      = 3'd0,
    CFG_ORG_LON      = 3'd1,
    CFG_ROWS_PER_DEG = 3'd2,
    CFG_COLS_PER_DEG = 3'd3,
    CFG_ROWS_IN_USE  = 3'd4,
    CFG_COLS_IN_USE  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic a;
    logic b;
  } stage_en_t;

endpackage

// File: design/tbe_ifs.sv
interface tbe_in_if;
  logic                                valid;
  logic                                ready;
  logic [tbe_pkg::MODE_W-1:0]          mode;
  logic [tbe_pkg::IDX_W-1:0]           row_index;
  logic [tbe_pkg::IDX_W-1:0]           col_index;
  logic signed [tbe_pkg::ELEV_W-1:0]   elevation_in;
  logic signed [tbe_pkg::LAT_W-1:0]    latitude;
  logic signed [tbe_pkg::LON_W-1:0]    longitude;

  modport source (output valid, mode, row_index, col_index, elevation_in, latitude, longitude,
                  input ready);
  modport sink (input valid, mode, row_index, col_index, elevation_in, latitude, longitude,
                output ready);
endinterface

interface tbe_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tbe_pkg::ELEV_W-1:0]   elevation_out;
  logic                                inside_grid;
  logic                                index_error;

  modport source (output valid, elevation_out, inside_grid, index_error, input ready);
  modport sink (input valid, elevation_out, inside_grid, index_error, output ready);
endinterface

// File: design/tbe_axis.sv
module tbe_axis #(
  parameter int POS_W         = tbe_pkg::LAT_W,
  parameter int DIM_MAX       = tbe_pkg::MAX_ROWS_DEF,
  parameter int FRACTION_BITS = tbe_pkg::FRACTION_BITS_DEF,
  localparam int DIW          = $clog2(DIM_MAX),
  localparam int QW           = DIW + FRACTION_BITS
) (
  input  logic                          clk,
  input  tbe_pkg::stage_en_t            en,
  input  logic signed [POS_W-1:0]       pos,
  input  logic signed [POS_W-1:0]       org,
  input  logic [tbe_pkg::RATE_W-1:0]    rate,
  input  logic [DIW-1:0]                top,
  output logic [QW-1:0]                 q_r,
  output logic                          inside_r
);

  localparam int HI_W = tbe_pkg::RATE_W - tbe_pkg::RATE_FRAC;
  localparam int PH_W = POS_W + HI_W;
  localparam int PL_W = POS_W + tbe_pkg::RATE_FRAC;
  localparam int PRW  = POS_W + tbe_pkg::RATE_W;

  logic signed [POS_W:0] diff;
  logic                  neg;
  logic [POS_W-1:0]      mag;
  logic                  neg_r;
  logic [PH_W-1:0]       phi_r;
  logic [PL_W-1:0]       plo_r;
  logic [PRW-1:0]        prod;
  logic [PRW-1:0]        limit;
  logic [QW-1:0]         q_nxt;
  logic                  inside_nxt;

  assign diff = (POS_W+1)'(pos) - (POS_W+1)'(org);
  assign neg  = diff[POS_W];
  assign mag  = neg ? POS_W'(-diff) : POS_W'(diff);

  always_ff @(posedge clk) begin
    if (en.a) begin
      neg_r <= neg;
      phi_r <= PH_W'(mag) * PH_W'(rate[tbe_pkg::RATE_W-1:tbe_pkg::RATE_FRAC]);
      plo_r <= PL_W'(mag) * PL_W'(rate[tbe_pkg::RATE_FRAC-1:0]);
    end
  end

  assign prod  = (PRW'(phi_r) << tbe_pkg::RATE_FRAC) + PRW'(plo_r);
  assign limit = PRW'(top) << tbe_pkg::PROD_FRAC;

  always_comb begin
    if (neg_r) begin
      q_nxt      = '0;
      inside_nxt = (prod == '0);
    end else if (prod > limit) begin
      q_nxt      = QW'(top) << FRACTION_BITS;
      inside_nxt = 1'b0;
    end else begin
      q_nxt      = prod[tbe_pkg::PROD_FRAC-FRACTION_BITS +: QW];
      inside_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en.b) begin
      q_r      <= q_nxt;
      inside_r <= inside_nxt;
    end
  end

endmodule

// File: design/terrain_bilinear_elevation_core.sv
// Channel  Direction  Payload
// in_if    sink       mode, row_index, col_index, elevation_in, latitude, longitude
// out_if   source     elevation_out, inside_grid, index_error
// cfg_*    write      cfg_index selects the register, cfg_data carries its value
//
// One beat is taken per cycle while the pipeline can advance and no clearing pass runs; a result
// is presented once its beat has passed the registered stages A to F.
// The four grid banks (row parity by column parity) give all four corners in one read.
// After reset a clearing pass zeroes the banks, one address per cycle in all banks, until
// every address is cleared; no input beat is taken meanwhile.
// Each stage holds when the next is full, so a stall loses and repeats nothing.
module terrain_bilinear_elevation_core #(
  parameter int MAX_ROWS      = tbe_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS      = tbe_pkg::MAX_COLS_DEF,
  parameter int FRACTION_BITS = tbe_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  tbe_in_if.sink                           in_if,
  tbe_out_if.source                        out_if,
  input  logic                             cfg_we,
  input  logic [tbe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tbe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int EW    = tbe_pkg::ELEV_W;
  localparam int FB    = FRACTION_BITS;
  localparam int RIW   = $clog2(MAX_ROWS);
  localparam int CIW   = $clog2(MAX_COLS);
  localparam int RDW   = $clog2(MAX_ROWS + 1);
  localparam int CDW   = $clog2(MAX_COLS + 1);
  localparam int RHW   = (RIW > 1) ? RIW - 1 : 1;
  localparam int CHW   = (CIW > 1) ? CIW - 1 : 1;
  localparam int BAW   = RHW + CHW;
  localparam int DEPTH = 1 << BAW;
  localparam int QRW   = RIW + FB;
  localparam int QCW   = CIW + FB;
  localparam int FW    = FB + 1;
  localparam int RCW   = (RDW > tbe_pkg::IDX_W) ? RDW : tbe_pkg::IDX_W;
  localparam int CCW   = (CDW > tbe_pkg::IDX_W) ? CDW : tbe_pkg::IDX_W;
  localparam int PMW   = EW + FW + 1;
  localparam int AHW   = PMW - FB;
  localparam int HPW   = AHW + FW + 1;
  localparam int LPW   = FB + FW;
  localparam int HW    = HPW + 1;
  localparam int LSW   = LPW + 1;
  localparam int H2W   = HW + 1;

  localparam logic [FW-1:0] W_ONE = {1'b1, {FB{1'b0}}};

  // Configuration registers.
  logic signed [tbe_pkg::LAT_W-1:0] org_lat_r;
  logic signed [tbe_pkg::LON_W-1:0] org_lon_r;
  logic [tbe_pkg::RATE_W-1:0]       rpd_r;
  logic [tbe_pkg::RATE_W-1:0]       cpd_r;
  logic [tbe_pkg::DIM_W-1:0]        rows_r;
  logic [tbe_pkg::DIM_W-1:0]        cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_lat_r <= '0;
      org_lon_r <= '0;
      rpd_r     <= tbe_pkg::RATE_RST;
      cpd_r     <= tbe_pkg::RATE_RST;
      rows_r    <= tbe_pkg::DIM_RST;
      cols_r    <= tbe_pkg::DIM_RST;
    end else if (cfg_we) begin
      case (tbe_pkg::cfg_idx_t'(cfg_index))
        tbe_pkg::CFG_ORG_LAT:      org_lat_r <= cfg_data[tbe_pkg::LAT_W-1:0];
        tbe_pkg::CFG_ORG_LON:      org_lon_r <= cfg_data[tbe_pkg::LON_W-1:0];
        tbe_pkg::CFG_ROWS_PER_DEG: rpd_r     <= cfg_data[tbe_pkg::RATE_W-1:0];
        tbe_pkg::CFG_COLS_PER_DEG: cpd_r     <= cfg_data[tbe_pkg::RATE_W-1:0];
        tbe_pkg::CFG_ROWS_IN_USE:  rows_r    <= cfg_data[tbe_pkg::DIM_W-1:0];
        tbe_pkg::CFG_COLS_IN_USE:  cols_r    <= cfg_data[tbe_pkg::DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic [RDW-1:0] nr;
  logic [CDW-1:0] nc;
  logic [RIW-1:0] row_top;
  logic [CIW-1:0] col_top;

  always_comb begin
    if (int'(rows_r) < 2) begin
      nr = RDW'(2);
    end else if (int'(rows_r) > MAX_ROWS) begin
      nr = RDW'(MAX_ROWS);
    end else begin
      nr = RDW'(rows_r);
    end
    if (int'(cols_r) < 2) begin
      nc = CDW'(2);
    end else if (int'(cols_r) > MAX_COLS) begin
      nc = CDW'(MAX_COLS);
    end else begin
      nc = CDW'(cols_r);
    end
  end

  assign row_top = RIW'(nr - RDW'(1));
  assign col_top = CIW'(nc - CDW'(1));

  // Stage handshake.
  logic va_r, vb_r, vc_r, vd_r, ve_r, vf_r;
  logic en_a, en_b, en_c, en_d, en_e, en_f;
  logic clr_busy_r;
  logic [BAW-1:0] clr_cnt_r;
  logic in_fire;

  assign en_f = !vf_r || out_if.ready;
  assign en_e = !ve_r || en_f;
  assign en_d = !vd_r || en_e;
  assign en_c = !vc_r || en_d;
  assign en_b = !vb_r || en_c;
  assign en_a = !va_r || en_b;
  assign in_if.ready = en_a && !clr_busy_r;
  assign in_fire = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
    end else begin
      if (en_a) begin
        va_r <= in_fire;
      end
      if (en_b) begin
        vb_r <= va_r;
      end
      if (en_c) begin
        vc_r <= vb_r;
      end
      if (en_d) begin
        vd_r <= vc_r;
      end
      if (en_e) begin
        ve_r <= vd_r;
      end
      if (en_f) begin
        vf_r <= ve_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + BAW'(1);
      if (clr_cnt_r == '1) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Stage A: index check, axis subtraction and partial products.
  logic [tbe_pkg::MODE_W-1:0] a_mode_r, b_mode_r, c_mode_r, d_mode_r, e_mode_r;
  logic [tbe_pkg::IDX_W-1:0]  a_row_r, a_col_r, b_row_r, b_col_r;
  logic signed [EW-1:0]       a_elev_r, b_elev_r;
  logic                       a_err_r, b_err_r, c_err_r, d_err_r, e_err_r;
  logic                       a_err_nxt;

  assign a_err_nxt = (RCW'(in_if.row_index) >= RCW'(nr)) || (CCW'(in_if.col_index) >= CCW'(nc));

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_mode_r <= in_if.mode;
      a_row_r  <= in_if.row_index;
      a_col_r  <= in_if.col_index;
      a_elev_r <= in_if.elevation_in;
      a_err_r  <= a_err_nxt;
    end
  end

  tbe_pkg::stage_en_t axis_en;
  logic [QRW-1:0] q_row;
  logic [QCW-1:0] q_col;
  logic           ins_row, ins_col;

  assign axis_en.a = en_a;
  assign axis_en.b = en_b;

  tbe_axis #(
    .POS_W(tbe_pkg::LAT_W), .DIM_MAX(MAX_ROWS), .FRACTION_BITS(FRACTION_BITS)
  ) u_axis_row (
    .clk(clk), .en(axis_en), .pos(in_if.latitude), .org(org_lat_r), .rate(rpd_r),
    .top(row_top), .q_r(q_row), .inside_r(ins_row)
  );

  tbe_axis #(
    .POS_W(tbe_pkg::LON_W), .DIM_MAX(MAX_COLS), .FRACTION_BITS(FRACTION_BITS)
  ) u_axis_col (
    .clk(clk), .en(axis_en), .pos(in_if.longitude), .org(org_lon_r), .rate(cpd_r),
    .top(col_top), .q_r(q_col), .inside_r(ins_col)
  );

  // Stage B: products are combined and clamped inside the axis units.
  always_ff @(posedge clk) begin
    if (en_b) begin
      b_mode_r <= a_mode_r;
      b_row_r  <= a_row_r;
      b_col_r  <= a_col_r;
      b_elev_r <= a_elev_r;
      b_err_r  <= a_err_r;
    end
  end

  // Stage C: corner selection and bank access.
  logic [RIW-1:0] r0_raw, r0, r0_ev, r0_od;
  logic [CIW-1:0] c0_raw, c0, c0_ev, c0_od;
  logic [FW-1:0]  fy_nxt, fx_nxt;
  logic           b_query;
  logic [1:0]     sel_nxt;
  logic [BAW-1:0] bank_addr [4];
  logic [3:0]     bank_we;
  logic signed [EW-1:0] bank_wdata;
  logic signed [EW-1:0] rd_r [4];

  assign b_query = (b_mode_r == tbe_pkg::MODE_QUERY);

  always_comb begin
    r0_raw = q_row[QRW-1:FB];
    c0_raw = q_col[QCW-1:FB];
    r0 = (r0_raw >= row_top) ? row_top - RIW'(1) : r0_raw;
    c0 = (c0_raw >= col_top) ? col_top - CIW'(1) : c0_raw;
    fy_nxt = FW'(q_row - (QRW'(r0) << FB));
    fx_nxt = FW'(q_col - (QCW'(c0) << FB));
    r0_ev = r0[0] ? r0 + RIW'(1) : r0;
    r0_od = r0[0] ? r0 : r0 + RIW'(1);
    c0_ev = c0[0] ? c0 + CIW'(1) : c0;
    c0_od = c0[0] ? c0 : c0 + CIW'(1);
    sel_nxt = b_query ? {r0[0], c0[0]} : {b_row_r[0], b_col_r[0]};
    bank_wdata = clr_busy_r ? '0 : b_elev_r;
    for (int b = 0; b < 4; b++) begin
      if (clr_busy_r) begin
        bank_addr[b] = clr_cnt_r;
        bank_we[b]   = 1'b1;
      end else if (b_query) begin
        bank_addr[b] = {(b[1] ? RHW'(r0_od >> 1) : RHW'(r0_ev >> 1)),
                        (b[0] ? CHW'(c0_od >> 1) : CHW'(c0_ev >> 1))};
        bank_we[b]   = 1'b0;
      end else begin
        bank_addr[b] = {RHW'(b_row_r >> 1), CHW'(b_col_r >> 1)};
        bank_we[b]   = vb_r && en_c && (b_mode_r == tbe_pkg::MODE_WRITE) && !b_err_r &&
                       (sel_nxt == 2'(b));
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic signed [EW-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
      if (bank_we[g]) begin
        mem[bank_addr[g]] <= bank_wdata;
      end
      if (en_c) begin
        rd_r[g] <= mem[bank_addr[g]];
      end
    end
  end

  logic [FW-1:0] c_fx_r, c_fy_r, d_fy_r;
  logic [1:0]    c_sel_r;
  logic          c_inside_r, d_inside_r, e_inside_r;

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_mode_r   <= b_mode_r;
      c_err_r    <= b_err_r;
      c_inside_r <= ins_row && ins_col;
      c_fx_r     <= fx_nxt;
      c_fy_r     <= fy_nxt;
      c_sel_r    <= sel_nxt;
    end
  end

  // Stage D: first blend products along the column axis.
  logic signed [EW-1:0]  e00, e01, e10, e11;
  logic signed [FW:0]    sx0, sx1;
  logic signed [PMW-1:0] d_m00_r, d_m01_r, d_m10_r, d_m11_r;
  logic signed [EW-1:0]  d_rd_r, e_rd_r;

  always_comb begin
    e00 = rd_r[c_sel_r];
    e01 = rd_r[{c_sel_r[1], ~c_sel_r[0]}];
    e10 = rd_r[{~c_sel_r[1], c_sel_r[0]}];
    e11 = rd_r[~c_sel_r];
    sx0 = {1'b0, W_ONE - c_fx_r};
    sx1 = {1'b0, c_fx_r};
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_m00_r    <= PMW'(e00) * PMW'(sx0);
      d_m01_r    <= PMW'(e01) * PMW'(sx1);
      d_m10_r    <= PMW'(e10) * PMW'(sx0);
      d_m11_r    <= PMW'(e11) * PMW'(sx1);
      d_rd_r     <= e00;
      d_fy_r     <= c_fy_r;
      d_mode_r   <= c_mode_r;
      d_err_r    <= c_err_r;
      d_inside_r <= c_inside_r;
    end
  end

  // Stage E: row blend, split into high and low parts to keep it exact.
  logic signed [PMW-1:0] a0, a1;
  logic signed [AHW-1:0] a0h, a1h;
  logic [FB-1:0]         a0l, a1l;
  logic [FW-1:0]         wy0;
  logic signed [FW:0]    sy0, sy1;
  logic signed [HPW-1:0] e_h0_r, e_h1_r;
  logic [LPW-1:0]        e_l0_r, e_l1_r;

  always_comb begin
    a0  = d_m00_r + d_m01_r;
    a1  = d_m10_r + d_m11_r;
    a0h = AHW'(a0 >>> FB);
    a1h = AHW'(a1 >>> FB);
    a0l = a0[FB-1:0];
    a1l = a1[FB-1:0];
    wy0 = W_ONE - d_fy_r;
    sy0 = {1'b0, wy0};
    sy1 = {1'b0, d_fy_r};
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      e_h0_r     <= HPW'(a0h) * HPW'(sy0);
      e_h1_r     <= HPW'(a1h) * HPW'(sy1);
      e_l0_r     <= LPW'(a0l) * LPW'(wy0);
      e_l1_r     <= LPW'(a1l) * LPW'(d_fy_r);
      e_rd_r     <= d_rd_r;
      e_mode_r   <= d_mode_r;
      e_err_r    <= d_err_r;
      e_inside_r <= d_inside_r;
    end
  end

  // Stage F: sum, round half up and select the result.
  logic signed [HW-1:0]  hs;
  logic [LSW-1:0]        ls;
  logic signed [H2W-1:0] h2, rnd, val;
  logic signed [EW-1:0]  f_elev_nxt;
  logic                  f_inside_nxt, f_err_nxt;
  logic signed [EW-1:0]  f_elev_r;
  logic                  f_inside_r, f_err_r;

  always_comb begin
    hs  = HW'(e_h0_r) + HW'(e_h1_r);
    ls  = LSW'(e_l0_r) + LSW'(e_l1_r);
    h2  = H2W'(hs) + $signed(H2W'(ls >> FB));
    rnd = h2 + $signed(H2W'(1) << (FB - 1));
    val = rnd >>> FB;
    f_elev_nxt   = '0;
    f_inside_nxt = 1'b0;
    f_err_nxt    = 1'b0;
    case (e_mode_r)
      tbe_pkg::MODE_WRITE: begin
        f_err_nxt = e_err_r;
      end
      tbe_pkg::MODE_READ: begin
        f_err_nxt  = e_err_r;
        f_elev_nxt = e_err_r ? '0 : e_rd_r;
      end
      tbe_pkg::MODE_QUERY: begin
        f_inside_nxt = e_inside_r;
        f_elev_nxt   = EW'(val);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      f_elev_r   <= f_elev_nxt;
      f_inside_r <= f_inside_nxt;
      f_err_r    <= f_err_nxt;
    end
  end

  assign out_if.valid         = vf_r;
  assign out_if.elevation_out = f_elev_r;
  assign out_if.inside_grid   = f_inside_r;
  assign out_if.index_error   = f_err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vf_r && f_err_r |-> f_elev_r == '0)
    else $error("index error beat carries a nonzero elevation");

  a_err_inside: assert property (@(posedge clk) disable iff (!rst_n)
    vf_r |-> !(f_inside_r && f_err_r))
    else $error("inside flag and index error raised together");

  a_clr_once: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_busy_r |=> !clr_busy_r)
    else $error("clearing pass restarted");

  a_clr_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !(va_r || vb_r || vc_r))
    else $error("pipeline holds an item during the clearing pass");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    ve_r && en_f |=> vf_r)
    else $error("item lost between the last two stages");

endmodule
